### rtl/core/rsmp_pkg.sv
package rsmp_pkg;

	// Matrix dimension limits and derived widths.
	localparam int MAX_DIM = 8;
	localparam int DIM_W = 4;
	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int IDX_W = CNT_W + DIM_W + 1;

	// Element stores: one word pair per entry, high share in the upper half.
	localparam int WORD_W = 64;
	localparam int PAIR_W = 2 * WORD_W;
	localparam int HALF_W = WORD_W / 2;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = 6;

	// Action codes of an input item.
	localparam logic [1:0] ACT_LOAD_A = 2'd0;
	localparam logic [1:0] ACT_LOAD_B = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_M = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INNER_K = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLS_N = 2'd2;

	// Partial product steps of one term: a_lo*(b_lo+b_hi) then a_hi*b_lo.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_P0_LL = 3'd0;
	localparam logic [STEP_W-1:0] STEP_P0_LH = 3'd1;
	localparam logic [STEP_W-1:0] STEP_P0_HL = 3'd2;
	localparam logic [STEP_W-1:0] STEP_P1_LL = 3'd3;
	localparam logic [STEP_W-1:0] STEP_P1_LH = 3'd4;
	localparam logic [STEP_W-1:0] STEP_P1_HL = 3'd5;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_P1_HL;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic                clear;
		logic                latch;
		logic                mul_en;
		logic [STEP_W-1:0]   step;
	} mac_ctrl_t;

	// A dimension register of zero acts as one, above MAX_DIM as MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	// Row-major index row*dim+col, wrapped to the store depth.
	function automatic logic [ADDR_W-1:0] rm_index(input logic [CNT_W-1:0] row,
			input logic [DIM_W-1:0] dim, input logic [CNT_W-1:0] col);
		logic [IDX_W-1:0] p;
		p = IDX_W'(row) * IDX_W'(dim) + IDX_W'(col);
		return p[ADDR_W-1:0];
	endfunction

endpackage

### rtl/core/replicated_share_matrix_product.sv
// Replicated-share matrix product. Load items (action 0 for A, 1 for B) write one
// element word pair and keep busy low, so loads can arrive every cycle while idle;
// a load whose index is at or beyond the configured matrix size is dropped.
// A compute item (action 2) raises busy and emits the low share of every C element
// in row-major order, one strobe cycle per element, with last on the final one.
// For each element, every inner term takes one store read, one operand latch, six
// passes through the single shared 32 by 32 multiplier and one final accumulate,
// and the sum is then registered as the result. Busy falls once the last element
// is registered. The receiver cannot stall: each result is valid for exactly one
// cycle. Write the dimension registers only while busy is low.
module replicated_share_matrix_product (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic [rsmp_pkg::ADDR_W-1:0]         elem_index,
	input  logic [rsmp_pkg::WORD_W-1:0]         share_low,
	input  logic [rsmp_pkg::WORD_W-1:0]         share_high,
	input  logic                                wr_en,
	input  logic [rsmp_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [rsmp_pkg::DIM_W-1:0]          wr_data,
	output logic                                strobe,
	output logic [rsmp_pkg::ADDR_W-1:0]         out_index,
	output logic [rsmp_pkg::WORD_W-1:0]         c_value,
	output logic                                last
);

	localparam int CW = rsmp_pkg::CNT_W;
	localparam int DW = rsmp_pkg::DIM_W;
	localparam int AW = rsmp_pkg::ADDR_W;
	localparam int SZ_W = 2 * DW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_LATCH = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]                    state_q;
	logic [DW-1:0]                 rows_m_q, inner_k_q, cols_n_q;
	logic [DW-1:0]                 dim_m, dim_k, dim_n;
	logic [CW-1:0]                 i_q, j_q, t_q;
	logic [rsmp_pkg::STEP_W-1:0]   step_q;
	logic                          take;
	logic                          a_we, b_we;
	logic [SZ_W-1:0]               size_a, size_b;
	logic [AW-1:0]                 a_raddr, b_raddr;
	logic [rsmp_pkg::PAIR_W-1:0]   a_rdata, b_rdata, load_pair;
	rsmp_pkg::mac_ctrl_t           mac_ctrl;
	logic [rsmp_pkg::WORD_W-1:0]   acc;
	logic                          last_t, last_elem;
	logic                          strobe_q, last_q;
	logic [AW-1:0]                 out_index_q;
	logic [rsmp_pkg::WORD_W-1:0]   c_value_q;

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= DW'(1);
			inner_k_q <= DW'(1);
			cols_n_q  <= DW'(1);
		end else if (wr_en) begin
			case (wr_index)
				rsmp_pkg::REG_ROWS_M:  rows_m_q  <= wr_data;
				rsmp_pkg::REG_INNER_K: inner_k_q <= wr_data;
				rsmp_pkg::REG_COLS_N:  cols_n_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign dim_m = rsmp_pkg::clamp_dim(rows_m_q);
	assign dim_k = rsmp_pkg::clamp_dim(inner_k_q);
	assign dim_n = rsmp_pkg::clamp_dim(cols_n_q);

	// Input transfer and store writes.
	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;
	assign size_a = SZ_W'(dim_m) * SZ_W'(dim_k);
	assign size_b = SZ_W'(dim_k) * SZ_W'(dim_n);
	assign a_we = take && (action == rsmp_pkg::ACT_LOAD_A) && (SZ_W'(elem_index) < size_a);
	assign b_we = take && (action == rsmp_pkg::ACT_LOAD_B) && (SZ_W'(elem_index) < size_b);
	assign load_pair = {share_high, share_low};

	// Store read addresses for the current inner term.
	assign a_raddr = rsmp_pkg::rm_index(i_q, dim_k, t_q);
	assign b_raddr = rsmp_pkg::rm_index(t_q, dim_n, j_q);

	rsmp_ram #(
		.WIDTH(rsmp_pkg::PAIR_W),
		.DEPTH(rsmp_pkg::STORE_DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (elem_index),
		.wdata (load_pair),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	rsmp_ram #(
		.WIDTH(rsmp_pkg::PAIR_W),
		.DEPTH(rsmp_pkg::STORE_DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (elem_index),
		.wdata (load_pair),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Multiply-accumulate control.
	always_comb begin
		mac_ctrl.clear  = (state_q == S_EMIT) || (state_q == S_IDLE);
		mac_ctrl.latch  = (state_q == S_LATCH);
		mac_ctrl.mul_en = (state_q == S_MUL);
		mac_ctrl.step   = step_q;
	end

	rsmp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a_pair (a_rdata),
		.b_pair (b_rdata),
		.acc    (acc)
	);

	assign last_t = (t_q == CW'(dim_k - DW'(1)));
	assign last_elem = (i_q == CW'(dim_m - DW'(1))) && (j_q == CW'(dim_n - DW'(1)));

	// Sequencer over rows, columns, inner terms and product steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			t_q     <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					i_q    <= '0;
					j_q    <= '0;
					t_q    <= '0;
					step_q <= '0;
					if (take && (action == rsmp_pkg::ACT_COMPUTE)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (step_q == rsmp_pkg::STEP_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (last_t) begin
						t_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_EMIT: begin
					if (last_elem) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_READ;
						if (j_q == CW'(dim_n - DW'(1))) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register: one strobe cycle per C element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			out_index_q <= rsmp_pkg::rm_index(i_q, dim_n, j_q);
			c_value_q   <= acc;
			last_q      <= last_elem;
		end
	end

	assign strobe = strobe_q;
	assign out_index = out_index_q;
	assign c_value = c_value_q;
	assign last = last_q;

endmodule

### rtl/core/rsmp_ram.sv
module rsmp_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/rsmp_mac.sv
module rsmp_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rsmp_pkg::mac_ctrl_t             ctrl,
	input  logic [rsmp_pkg::PAIR_W-1:0]     a_pair,
	input  logic [rsmp_pkg::PAIR_W-1:0]     b_pair,
	output logic [rsmp_pkg::WORD_W-1:0]     acc
);

	localparam int WW = rsmp_pkg::WORD_W;
	localparam int HW = rsmp_pkg::HALF_W;

	logic [WW-1:0] a_lo_q, a_hi_q, b_lo_q, b_sum_q;
	logic [HW-1:0] x_half, y_half;
	logic          shift_step;
	logic [WW-1:0] prod_s1;
	logic          prod_sh_s1;
	logic          prod_v_s1;
	logic [WW-1:0] acc_q;
	logic [WW-1:0] addend;

	// Operand latch; b_lo+b_hi folds two of the three products into one.
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			a_lo_q  <= a_pair[WW-1:0];
			a_hi_q  <= a_pair[2*WW-1:WW];
			b_lo_q  <= b_pair[WW-1:0];
			b_sum_q <= b_pair[WW-1:0] + b_pair[2*WW-1:WW];
		end
	end

	// Operand halves for the low 64 bits of a 64 by 64 product.
	always_comb begin
		x_half = a_lo_q[HW-1:0];
		y_half = b_sum_q[HW-1:0];
		shift_step = 1'b0;
		case (ctrl.step)
			rsmp_pkg::STEP_P0_LL: begin
				x_half = a_lo_q[HW-1:0];
				y_half = b_sum_q[HW-1:0];
			end
			rsmp_pkg::STEP_P0_LH: begin
				x_half = a_lo_q[HW-1:0];
				y_half = b_sum_q[WW-1:HW];
				shift_step = 1'b1;
			end
			rsmp_pkg::STEP_P0_HL: begin
				x_half = a_lo_q[WW-1:HW];
				y_half = b_sum_q[HW-1:0];
				shift_step = 1'b1;
			end
			rsmp_pkg::STEP_P1_LL: begin
				x_half = a_hi_q[HW-1:0];
				y_half = b_lo_q[HW-1:0];
			end
			rsmp_pkg::STEP_P1_LH: begin
				x_half = a_hi_q[HW-1:0];
				y_half = b_lo_q[WW-1:HW];
				shift_step = 1'b1;
			end
			rsmp_pkg::STEP_P1_HL: begin
				x_half = a_hi_q[WW-1:HW];
				y_half = b_lo_q[HW-1:0];
				shift_step = 1'b1;
			end
			default: begin
				x_half = '0;
				y_half = '0;
			end
		endcase
	end

	// Shared 32 by 32 multiplier, registered before the accumulator.
	always_ff @(posedge clk) begin
		prod_s1    <= WW'(x_half) * WW'(y_half);
		prod_sh_s1 <= shift_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= ctrl.mul_en;
		end
	end

	// Cross products land 32 bits up; their upper halves drop out mod 2^64.
	assign addend = prod_sh_s1 ? {prod_s1[HW-1:0], {HW{1'b0}}} : prod_s1;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule
